// ===== design/mpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpr_pkg
// Shared types and constants of the multisample pixel resolve unit.
// ----------------------------------------------------------------------------
package mpr_pkg;

   // Width of the sample count register.
   localparam int CFG_BITS = 5;
   // Width of one color byte.
   localparam int BYTE_BITS = 8;
   localparam logic [BYTE_BITS-1:0] BYTE_MAX = 8'hFF;
   localparam logic [BYTE_BITS-1:0] BYTE_ZERO = 8'h00;
   localparam logic [BYTE_BITS-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [CFG_BITS-1:0] CFG_RESET_COUNT = 5'd1;

   // Control from the sample counter to every channel lane.
   typedef struct packed {
      logic acc_en;    // a sample word is taken this cycle
      logic last;      // that word closes the pixel
      logic take;      // merge stage consumes the finished bytes
   } lane_ctl_type;

   // Status of one channel lane back to the merge stage.
   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [BYTE_BITS-1:0] value;
   } lane_status_type;

endpackage
`default_nettype wire

// ===== design/multisample_pixel_resolve_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multisample_pixel_resolve_unit
// Box-filter resolve: averages the samples of each pixel into one RGBA byte
// quadruple.
//
// Input words on the req_ channel carry one RGB sample each, signed fixed
// point. Every word is added into three channel accumulators. The word that
// completes the configured sample count closes the pixel: its totals go to
// three divider lanes, one per channel, and one RGBA word with alpha 255
// appears on the rsp_ channel.
// The closing word moves each lane to a prepare state, which either clamps
// the channel to 0 or 255 and finishes, or starts the 8-step restoring
// divider in that lane; the finished bytes go to the rsp_ output register.
// Non-closing words are taken one per cycle; a closing word waits while the
// lanes still hold the previous pixel, so pixels do not overlap in the lanes.
// The rsp_ output register lets the lanes finish while the receiver stalls;
// when it stays stalled the lanes hold their bytes and the next closing word
// is stalled. csr_wr_en writes the sample count (0 reads as 1, values above
// MAX_SAMPLES saturate). Reset sets the count to 1 and clears accumulators,
// sample counter and all valid flags.
// ----------------------------------------------------------------------------
module multisample_pixel_resolve_unit
   import mpr_pkg::*;
#(
   parameter int MAX_SAMPLES = 16,
   parameter int FRAC_BITS   = 8,
   parameter int SAMPLE_BITS = 20
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [CFG_BITS-1:0]           csr_wr_data,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_red,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_green,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_blue,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [BYTE_BITS-1:0]          rsp_out_red,
   output      logic [BYTE_BITS-1:0]          rsp_out_green,
   output      logic [BYTE_BITS-1:0]          rsp_out_blue,
   output      logic [BYTE_BITS-1:0]          rsp_out_alpha
);

   localparam int NW = $clog2(MAX_SAMPLES + 1);

   logic [CFG_BITS-1:0]  count_ff, count_in;
   logic [NW-1:0]        seen_ff, seen_in;
   logic [NW-1:0]        n_eff;
   logic [NW:0]          seen_p1;
   logic                 last;
   logic                 accept;
   logic                 lanes_busy;
   logic                 all_done;
   logic                 load;

   logic                 out_valid_ff, out_valid_in;
   logic [BYTE_BITS-1:0] red_ff, green_ff, blue_ff;

   lane_ctl_type         ctl;
   lane_status_type      st_red, st_green, st_blue;

   always_comb begin
      if (count_ff == '0) begin
         n_eff = NW'(1);
      end else if (int'(count_ff) > MAX_SAMPLES) begin
         n_eff = NW'(MAX_SAMPLES);
      end else begin
         n_eff = NW'(count_ff);
      end
   end

   assign seen_p1    = {1'b0, seen_ff} + (NW + 1)'(1);
   assign last       = (seen_p1 >= {1'b0, n_eff});
   assign lanes_busy = st_red.busy || st_green.busy || st_blue.busy;

   // Only the word that closes a pixel needs free lanes.
   assign req_stall  = last && lanes_busy;
   assign accept     = req_valid && !req_stall;

   assign all_done   = st_red.done && st_green.done && st_blue.done;
   assign load       = all_done && (!out_valid_ff || !rsp_stall);

   assign ctl.acc_en = accept;
   assign ctl.last   = last;
   assign ctl.take   = load;

   assign count_in = csr_wr_en ? csr_wr_data : count_ff;

   always_comb begin
      seen_in = seen_ff;
      if (accept) begin
         seen_in = last ? '0 : seen_p1[NW-1:0];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CFG_RESET_COUNT;
         seen_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         out_valid_ff <= out_valid_in;
      end
      if (load) begin
         red_ff   <= st_red.value;
         green_ff <= st_green.value;
         blue_ff  <= st_blue.value;
      end
   end

   mpr_lane #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .FRAC_BITS   (FRAC_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_lane_red (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_sample_red),
      .n_eff  (n_eff),
      .status (st_red)
   );

   mpr_lane #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .FRAC_BITS   (FRAC_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_lane_green (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_sample_green),
      .n_eff  (n_eff),
      .status (st_green)
   );

   mpr_lane #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .FRAC_BITS   (FRAC_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_lane_blue (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_sample_blue),
      .n_eff  (n_eff),
      .status (st_blue)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_red   = red_ff;
   assign rsp_out_green = green_ff;
   assign rsp_out_blue  = blue_ff;
   assign rsp_out_alpha = ALPHA_OPAQUE;

endmodule
`default_nettype wire

// ===== design/mpr_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpr_lane
// One color channel: accumulates samples, then averages, clamps and rounds
// the pixel total with an iterative bit-per-cycle divider.
// ----------------------------------------------------------------------------
module mpr_lane
   import mpr_pkg::*;
#(
   parameter int MAX_SAMPLES = 16,
   parameter int FRAC_BITS   = 8,
   parameter int SAMPLE_BITS = 20
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire lane_ctl_type                    ctl,
   input  wire logic signed [SAMPLE_BITS-1:0]   sample,
   input  wire logic [$clog2(MAX_SAMPLES+1)-1:0] n_eff,
   output lane_status_type                      status
);

   localparam int NW    = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_SAMPLES);
   localparam int BASE_W = (SUM_W > NW + FRAC_BITS) ? SUM_W : NW + FRAC_BITS;
   localparam int TW    = BASE_W + BYTE_BITS + 2;
   localparam int IW    = $clog2(BYTE_BITS);

   typedef enum logic [3:0] {
      L_IDLE = 4'b0001,
      L_PREP = 4'b0010,
      L_DIV  = 4'b0100,
      L_DONE = 4'b1000
   } lane_state_type;

   lane_state_type            state_ff, state_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [SUM_W-1:0]   total_ff, total_in;
   logic [NW-1:0]             n_ff, n_in;
   logic [TW-1:0]             rem_ff, rem_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic [BYTE_BITS-1:0]      q_ff, q_in;

   logic signed [SUM_W-1:0]   sum_next;
   logic [TW-1:0]             num;
   logic [TW-1:0]             dividend;
   logic [TW-1:0]             limit;
   logic [TW-1:0]             dsh;
   logic                      nonpos;

   assign sum_next = sum_ff + SUM_W'(sample);

   // Rounding half up: floor((2*sum + d) / (2*d)) with d = n << FRAC_BITS,
   // which equals floor(((2*sum + d) >> (FRAC_BITS + 1)) / n).
   assign num      = (TW'(total_ff) << 1) + (TW'(n_ff) << FRAC_BITS);
   assign dividend = num >> (FRAC_BITS + 1);
   assign limit    = TW'(n_ff) << BYTE_BITS;
   assign nonpos   = total_ff[SUM_W-1] || (total_ff == '0);
   assign dsh      = TW'(n_ff) << idx_ff;

   always_comb begin
      sum_in   = sum_ff;
      total_in = total_ff;
      n_in     = n_ff;
      state_in = state_ff;
      rem_in   = rem_ff;
      idx_in   = idx_ff;
      q_in     = q_ff;

      if (ctl.acc_en) begin
         if (ctl.last) begin
            sum_in   = '0;
            total_in = sum_next;
            n_in     = n_eff;
         end else begin
            sum_in = sum_next;
         end
      end

      case (state_ff)
         L_IDLE: begin
            if (ctl.acc_en && ctl.last) begin
               state_in = L_PREP;
            end
         end
         L_PREP: begin
            rem_in = dividend;
            idx_in = IW'(BYTE_BITS - 1);
            q_in   = BYTE_ZERO;
            if (nonpos) begin
               state_in = L_DONE;
            end else if (dividend >= limit) begin
               q_in     = BYTE_MAX;
               state_in = L_DONE;
            end else begin
               state_in = L_DIV;
            end
         end
         L_DIV: begin
            if (rem_ff >= dsh) begin
               rem_in       = rem_ff - dsh;
               q_in[idx_ff] = 1'b1;
            end
            if (idx_ff == '0) begin
               state_in = L_DONE;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         L_DONE: begin
            if (ctl.take) begin
               state_in = L_IDLE;
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
      end
      total_ff <= total_in;
      n_ff     <= n_in;
      rem_ff   <= rem_in;
      idx_ff   <= idx_in;
      q_ff     <= q_in;
   end

   assign status.busy  = (state_ff != L_IDLE);
   assign status.done  = (state_ff == L_DONE);
   assign status.value = q_ff;

endmodule
`default_nettype wire

// ===== design/mpr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpr_checker
// Port-level checks of the multisample pixel resolve unit.
// ----------------------------------------------------------------------------
module mpr_checker
   import mpr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic [BYTE_BITS-1:0] rsp_out_red,
   input  wire logic [BYTE_BITS-1:0] rsp_out_green,
   input  wire logic [BYTE_BITS-1:0] rsp_out_blue,
   input  wire logic [BYTE_BITS-1:0] rsp_out_alpha
);

   // A stalled result word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_red)
         && $stable(rsp_out_green) && $stable(rsp_out_blue))
      else $error("stalled result word changed");

   // Every pixel leaves fully opaque.
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_alpha == ALPHA_OPAQUE)
      else $error("alpha byte is not opaque");

   // No result word survives a reset.
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind multisample_pixel_resolve_unit mpr_checker u_mpr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_red   (rsp_out_red),
   .rsp_out_green (rsp_out_green),
   .rsp_out_blue  (rsp_out_blue),
   .rsp_out_alpha (rsp_out_alpha)
);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multisample pixel resolve unit. Sample words go
// in with random gaps while the pixel side stalls at random. A scoreboard
// keeps its own running sums and predicts every RGBA word. The run covers
// rounding and clamping edges, directed and random sample count settings
// including zero and saturated values, and mid-pixel count changes.
// ----------------------------------------------------------------------------
module testbench;
   import mpr_pkg::*;

   localparam int SAMPLE_W  = 20;
   localparam int FRAC_W    = 8;
   localparam int MAX_COUNT = 16;
   localparam int SETTLE    = 16;
   localparam int STUCK_LIMIT = 4000;
   localparam int PHASES    = 12;
   localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 20'sh7FFFF;
   localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 20'sh80000;

   typedef struct packed {
      logic [BYTE_BITS-1:0] red;
      logic [BYTE_BITS-1:0] green;
      logic [BYTE_BITS-1:0] blue;
      logic [BYTE_BITS-1:0] alpha;
   } rgba_type;

   // Predicts resolved pixels from accepted sample words and checks them.
   class pixel_scoreboard;
      logic [CFG_BITS-1:0] count_reg;
      longint red_acc;
      longint green_acc;
      longint blue_acc;
      int unsigned taken;
      rgba_type pixel_q[$];
      int errors;
      int pixels_checked;
      int samples_noted;

      function new();
         clear();
      endfunction

      function void clear();
         count_reg = CFG_RESET_COUNT;
         red_acc = 0;
         green_acc = 0;
         blue_acc = 0;
         taken = 0;
         pixel_q.delete();
         errors = 0;
         pixels_checked = 0;
         samples_noted = 0;
      endfunction

      function void set_count(logic [CFG_BITS-1:0] value);
         count_reg = value;
      endfunction

      function int unsigned active_count();
         if (count_reg == 0) return 1;
         if (count_reg > MAX_COUNT) return MAX_COUNT;
         return count_reg;
      endfunction

      // Average, clamp to a byte and round half up, all in exact integers.
      function logic [BYTE_BITS-1:0] resolve(longint acc, int unsigned n);
         longint d;
         longint q;
         d = longint'(n) << FRAC_W;
         if (acc <= 0) return BYTE_ZERO;
         q = (2 * acc + d) / (2 * d);
         if (q > 255) return BYTE_MAX;
         return q[BYTE_BITS-1:0];
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] r,
                                logic signed [SAMPLE_W-1:0] g,
                                logic signed [SAMPLE_W-1:0] b);
         int unsigned n;
         rgba_type px;
         n = active_count();
         samples_noted++;
         red_acc += longint'(r);
         green_acc += longint'(g);
         blue_acc += longint'(b);
         taken++;
         if (taken >= n) begin
            px.red = resolve(red_acc, n);
            px.green = resolve(green_acc, n);
            px.blue = resolve(blue_acc, n);
            px.alpha = ALPHA_OPAQUE;
            pixel_q.push_back(px);
            red_acc = 0;
            green_acc = 0;
            blue_acc = 0;
            taken = 0;
         end
      endfunction

      function void check_pixel(rgba_type got);
         rgba_type want;
         if (pixel_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected pixel word r=%0d g=%0d b=%0d a=%0d",
                        $realtime, got.red, got.green, got.blue, got.alpha);
            return;
         end
         want = pixel_q.pop_front();
         pixels_checked++;
         if (got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.alpha !== want.alpha) begin
            errors++;
            if (errors <= 10)
               $display("%0t: pixel %0d mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                        $realtime, pixels_checked, want.red, want.green, want.blue,
                        want.alpha, got.red, got.green, got.blue, got.alpha);
         end
      endfunction

      function int pending();
         return pixel_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CFG_BITS-1:0] csr_wr_data;
   logic req_valid;
   logic req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_red;
   logic signed [SAMPLE_W-1:0] req_sample_green;
   logic signed [SAMPLE_W-1:0] req_sample_blue;
   logic rsp_valid;
   logic rsp_stall;
   logic [BYTE_BITS-1:0] rsp_out_red;
   logic [BYTE_BITS-1:0] rsp_out_green;
   logic [BYTE_BITS-1:0] rsp_out_blue;
   logic [BYTE_BITS-1:0] rsp_out_alpha;

   pixel_scoreboard sb;
   bit calm;
   int idle_pct;
   int stall_pct;
   int stuck;

   multisample_pixel_resolve_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_red   (req_sample_red),
      .req_sample_green (req_sample_green),
      .req_sample_blue  (req_sample_blue),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_alpha    (rsp_out_alpha)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Pixel-side backpressure in random bursts.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_sample(req_sample_red, req_sample_green, req_sample_blue);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_pixel('{rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha});
      if (!reset && csr_wr_en)
         sb.set_count(csr_wr_data);
   end

   // Watchdog on cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck <= 0;
      else
         stuck <= stuck + 1;
      if (stuck >= STUCK_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $realtime, stuck);
         $display("multisample_pixel_resolve_unit test failed");
         $finish;
      end
   end

   // All driving tasks start and end just after a falling edge.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] r,
                              input logic signed [SAMPLE_W-1:0] g,
                              input logic signed [SAMPLE_W-1:0] b);
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_red <= r;
      req_sample_green <= g;
      req_sample_blue <= b;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   // Holds the sender off until every predicted pixel has come out.
   task automatic wait_idle(input int settle);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_count(input logic [CFG_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int sel;
      int v;
      sel = $urandom_range(0, 7);
      case (sel)
         0: begin
            v = $urandom;
         end
         1: begin
            case ($urandom_range(0, 6))
               0: v = SMP_MAX;
               1: v = SMP_MIN;
               2: v = 0;
               3: v = -1;
               4: v = 1;
               5: v = 255 << FRAC_W;
               default: v = 1 << (FRAC_W - 1);
            endcase
         end
         default: begin
            // Mostly ordinary colors with a little overshoot on both sides.
            v = int'($urandom_range(0, (256 << FRAC_W) + 255)) - 128;
         end
      endcase
      return v[SAMPLE_W-1:0];
   endfunction

   initial begin
      logic [CFG_BITS-1:0] count_plan [8];
      int items;
      sb = new();
      count_plan = '{5'd16, 5'd31, 5'd2, 5'd0, 5'd1, 5'd17, 5'd5, 5'd3};
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_sample_red = '0;
      req_sample_green = '0;
      req_sample_blue = '0;
      calm = 1'b0;
      idle_pct = 20;
      stall_pct = 20;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // One sample per pixel after reset: range ends, rounding ties, clamps.
      send_sample(0, 0, 0);
      send_sample(SMP_MAX, SMP_MIN, 0);
      send_sample(128, 127, 129);
      send_sample(65280, 65152, 65151);
      send_sample(-1, 1, 256);
      send_sample(384, 640, 32768);
      send_sample(SMP_MIN, SMP_MAX, SMP_MIN);
      wait_idle(SETTLE);
      // A count of zero behaves as one.
      write_count(5'd0);
      send_sample(200 << FRAC_W, 100 << FRAC_W, 50 << FRAC_W);
      send_sample(SMP_MAX, -256, 1);
      wait_idle(SETTLE);
      write_count(5'd3);
      send_sample(256, 256, SMP_MAX);
      send_sample(256, 0, SMP_MAX);
      send_sample(0, 128, SMP_MAX);
      wait_idle(SETTLE);
      // Lower the count while a pixel is half collected.
      write_count(5'd4);
      send_sample(1000, 2000, 3000);
      send_sample(1100, 2100, 3100);
      wait_idle(SETTLE);
      write_count(5'd2);
      send_sample(1200, 2200, 3200);
      send_sample(SMP_MAX, SMP_MAX, SMP_MAX);
      send_sample(SMP_MAX, SMP_MAX, SMP_MAX);
      wait_idle(SETTLE);

      for (int phase = 0; phase < PHASES; phase++) begin
         calm = (phase == PHASES - 1);
         idle_pct = calm ? 0 : 10 * $urandom_range(0, 4);
         stall_pct = calm ? 0 : 10 * $urandom_range(0, 4);
         wait_idle(SETTLE);
         if (phase < 8)
            write_count(count_plan[phase]);
         else
            write_count(CFG_BITS'($urandom_range(0, 31)));
         items = $urandom_range(100, 180);
         for (int k = 0; k < items; k++) begin
            if (phase == 5 && k == items / 2)
               wait_idle(0);
            send_sample(pick_sample(), pick_sample(), pick_sample());
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Summary: %0d sample words sent, %0d pixels checked, %0d mismatches.",
               sb.samples_noted, sb.pixels_checked, sb.errors);
      $display("Counts 0 to 31 with saturation, mid-pixel count changes and rounding edges.");
      if (sb.errors == 0 && sb.pending() == 0)
         $display("multisample_pixel_resolve_unit test passed");
      else
         $display("multisample_pixel_resolve_unit test failed");
      $finish;
   end

endmodule
